>>> hdl/obce_pkg.sv
`default_nettype none

package obce_pkg;

  // Configuration register indexes.
  localparam logic [0:0] REG_BOX_WIDTH  = 1'b0;
  localparam logic [0:0] REG_BOX_HEIGHT = 1'b1;

  // Field widths.
  localparam int unsigned DIM_W   = 31;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned TRIG_W  = 16;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_A_W = 40;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Half extent is the Q8.8 scaled size shifted down by nine.
  localparam int unsigned HALF_SHIFT = 9;
  localparam int unsigned HALF_W     = DIM_W + SCALE_W - HALF_SHIFT;

  // Rotation products and their rounded sums.
  localparam int unsigned ROT_W   = 55;
  localparam int unsigned SUM_W   = ROT_W + 1;
  localparam int unsigned TRIG_FRAC = 14;
  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (TRIG_FRAC - 1);

  // Query projections.
  localparam int unsigned PROJ_W = 34;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CORN,
    ST_QRY,
    ST_DONE
  } st_t;

  // Edge codes: top is corners 0-1, left 3-0, bottom 2-3, right 1-2.
  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_LEFT   = 2'd1,
    EDGE_BOTTOM = 2'd2,
    EDGE_RIGHT  = 2'd3
  } edge_t;

  // First corner of an edge.
  function automatic logic [1:0] edge_first(edge_t code);
    logic [1:0] idx;
    case (code)
      EDGE_TOP:    idx = 2'd0;
      EDGE_LEFT:   idx = 2'd3;
      EDGE_BOTTOM: idx = 2'd2;
      EDGE_RIGHT:  idx = 2'd1;
      default:     idx = 2'd0;
    endcase
    return idx;
  endfunction

  // Second corner of an edge.
  function automatic logic [1:0] edge_second(edge_t code);
    logic [1:0] idx;
    case (code)
      EDGE_TOP:    idx = 2'd1;
      EDGE_LEFT:   idx = 2'd0;
      EDGE_BOTTOM: idx = 2'd3;
      EDGE_RIGHT:  idx = 2'd2;
      default:     idx = 2'd1;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> hdl/obce_mul.sv
`default_nettype none

// Shared signed multiplier with a registered product.
module obce_mul (
  input  logic                                  clk,
  input  logic signed [obce_pkg::MUL_A_W-1:0]   a,
  input  logic signed [obce_pkg::MUL_B_W-1:0]   b,
  output logic signed [obce_pkg::MUL_P_W-1:0]   p_r
);

  // The product is registered before anything uses it.
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

`default_nettype wire

>>> hdl/oriented_box_corners_and_edge_select.sv
`default_nettype none
// Update and query words are taken one at a time: in_stall stays high from acceptance
// until the result word is loaded into the output register. The sequencer steps both
// kinds through one shared multiplier, and a query reads a one-port corner memory
// once per edge corner.
// Synchronous active-low reset clears sizes, extent and corner valid bits and sets the axes to identity.
module oriented_box_corners_and_edge_select (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic [15:0]        in_scale_x,
  input  logic [15:0]        in_scale_y,
  input  logic signed [15:0] in_cos_rot,
  input  logic signed [15:0] in_sin_rot,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_extent_min_x,
  output logic signed [31:0] out_extent_max_x,
  output logic signed [31:0] out_extent_min_y,
  output logic signed [31:0] out_extent_max_y,
  output logic [1:0]         out_edge_code,
  output logic signed [31:0] out_edge_start_x,
  output logic signed [31:0] out_edge_start_y,
  output logic signed [31:0] out_edge_end_x,
  output logic signed [31:0] out_edge_end_y,
  output logic               out_saturated
);

  obce_pkg::st_t state_r, state_nxt;
  logic [3:0]    step_r, step_nxt;
  logic          in_accept;
  logic          out_load;

  logic [30:0]   box_width_r, box_height_r;
  logic          cmd_r;
  logic signed [31:0] cx_r, cy_r;
  logic [15:0]   sx_r, sy_r;
  logic signed [15:0] nx_r, ny_r;
  logic signed [15:0] axis_cos_r, axis_sin_r;

  logic signed [obce_pkg::MUL_A_W-1:0] mul_a;
  logic signed [obce_pkg::MUL_B_W-1:0] mul_b;
  logic signed [obce_pkg::MUL_P_W-1:0] prod;

  logic [obce_pkg::HALF_W-1:0]       hw_r, hh_r;
  logic signed [obce_pkg::ROT_W-1:0] hwc_r, hws_r, hhc_r, hhs_r;

  logic signed [32:0]                 t_r;
  logic signed [obce_pkg::PROJ_W-1:0] px_r, py_r;
  logic [obce_pkg::PROJ_W-1:0]        ax, ay;
  obce_pkg::edge_t                    code_r, code_nxt;

  // Corner pipeline.
  logic                              s1_v_r, s2_v_r;
  logic [2:0]                        s1_k_r, s2_k_r;
  logic signed [obce_pkg::SUM_W-1:0] s1_sum_r, sum_nxt;
  logic signed [obce_pkg::SUM_W-1:0] term1, term2;
  logic signed [obce_pkg::ROT_W-1:0] op1, op2;
  logic                              neg1, neg2;
  logic signed [41:0]                shifted;
  logic signed [31:0]                ctr;
  logic signed [42:0]                pos_wide;
  logic                              ovf;
  logic signed [31:0]                sat_val, s2_val_r, x_hold_r;
  logic                              sat_r;

  logic signed [31:0] ext_min_x_r, ext_max_x_r, ext_min_y_r, ext_max_y_r;

  // Corner memory: {x, y} per corner.
  logic [63:0] corner_mem [4];
  logic [3:0]  vld_r;
  logic [1:0]  rd_addr;
  logic [63:0] rd_r, rdata, start_r, end_r;
  logic        rd_vld_r;

  logic               out_valid_r, out_sat_r;
  obce_pkg::edge_t    out_code_r;
  logic signed [31:0] out_min_x_r, out_max_x_r, out_min_y_r, out_max_y_r;
  logic signed [31:0] out_sx_r, out_sy_r, out_ex_r, out_ey_r;

  assign in_stall  = (state_r != obce_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == obce_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  obce_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= obce_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state, multiplier operands and memory read address.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    mul_a     = '0;
    mul_b     = '0;
    rd_addr   = obce_pkg::edge_first(code_r);
    case (state_r)
      obce_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = in_command ? obce_pkg::ST_QRY : obce_pkg::ST_MUL;
          step_nxt  = '0;
        end
      end
      obce_pkg::ST_MUL: begin
        step_nxt = step_r + 4'd1;
        case (step_r)
          4'd0: begin
            mul_a = {9'b0, box_width_r};
            mul_b = {1'b0, sx_r};
          end
          4'd1: begin
            mul_a = {9'b0, box_height_r};
            mul_b = {1'b0, sy_r};
          end
          4'd2: begin
            mul_a = {2'b0, hw_r};
            mul_b = {axis_cos_r[15], axis_cos_r};
          end
          4'd3: begin
            mul_a = {2'b0, hw_r};
            mul_b = {axis_sin_r[15], axis_sin_r};
          end
          4'd4: begin
            mul_a = {2'b0, hh_r};
            mul_b = {axis_cos_r[15], axis_cos_r};
          end
          4'd5: begin
            mul_a = {2'b0, hh_r};
            mul_b = {axis_sin_r[15], axis_sin_r};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
        if (step_r == 4'd6) begin
          state_nxt = obce_pkg::ST_CORN;
          step_nxt  = '0;
        end
      end
      obce_pkg::ST_CORN: begin
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd9) begin
          state_nxt = obce_pkg::ST_DONE;
        end
      end
      obce_pkg::ST_QRY: begin
        step_nxt = step_r + 4'd1;
        case (step_r)
          4'd0: begin
            mul_a = {{24{nx_r[15]}}, nx_r};
            mul_b = {axis_cos_r[15], axis_cos_r};
          end
          4'd1: begin
            mul_a = {{24{ny_r[15]}}, ny_r};
            mul_b = {axis_sin_r[15], axis_sin_r};
          end
          4'd2: begin
            mul_a = {{24{ny_r[15]}}, ny_r};
            mul_b = {axis_cos_r[15], axis_cos_r};
          end
          4'd3: begin
            mul_a = {{24{nx_r[15]}}, nx_r};
            mul_b = {axis_sin_r[15], axis_sin_r};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
        if (step_r == 4'd7) begin
          rd_addr = obce_pkg::edge_second(code_r);
        end
        if (step_r == 4'd8) begin
          state_nxt = obce_pkg::ST_DONE;
        end
      end
      obce_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = obce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = obce_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration, axes and corner valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_width_r  <= '0;
      box_height_r <= '0;
      axis_cos_r   <= 16'sd16384;
      axis_sin_r   <= '0;
      vld_r        <= '0;
    end else begin
      if (cfg_wr_en && cfg_index == obce_pkg::REG_BOX_WIDTH) begin
        box_width_r <= cfg_wdata;
      end
      if (cfg_wr_en && cfg_index == obce_pkg::REG_BOX_HEIGHT) begin
        box_height_r <= cfg_wdata;
      end
      if (in_accept && !in_command) begin
        axis_cos_r <= in_cos_rot;
        axis_sin_r <= in_sin_rot;
      end
      if (s1_v_r && s1_k_r[0]) begin
        vld_r[s1_k_r[2:1]] <= 1'b1;
      end
    end
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= in_command;
      cx_r  <= in_center_x;
      cy_r  <= in_center_y;
      sx_r  <= in_scale_x;
      sy_r  <= in_scale_y;
      nx_r  <= in_normal_x;
      ny_r  <= in_normal_y;
    end
  end

  // Half extents and rotation products from the shared multiplier.
  always_ff @(posedge clk) begin
    if (state_r == obce_pkg::ST_MUL) begin
      case (step_r)
        4'd1:    hw_r  <= prod[obce_pkg::HALF_SHIFT +: obce_pkg::HALF_W];
        4'd2:    hh_r  <= prod[obce_pkg::HALF_SHIFT +: obce_pkg::HALF_W];
        4'd3:    hwc_r <= prod[obce_pkg::ROT_W-1:0];
        4'd4:    hws_r <= prod[obce_pkg::ROT_W-1:0];
        4'd5:    hhc_r <= prod[obce_pkg::ROT_W-1:0];
        4'd6:    hhs_r <= prod[obce_pkg::ROT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage one: signed sum of two products plus the rounding bias.
  // Corner order is top-left, top-right, bottom-right, bottom-left; x before y.
  assign op1  = step_r[0] ? hws_r : hwc_r;
  assign op2  = step_r[0] ? hhc_r : hhs_r;
  assign neg1 = (step_r[1] == step_r[2]);
  assign neg2 = step_r[0] ? !step_r[2] : step_r[2];
  assign term1 = neg1 ? -{op1[obce_pkg::ROT_W-1], op1} : {op1[obce_pkg::ROT_W-1], op1};
  assign term2 = neg2 ? -{op2[obce_pkg::ROT_W-1], op2} : {op2[obce_pkg::ROT_W-1], op2};
  assign sum_nxt = term1 + term2 + obce_pkg::ROUND_BIAS;

  // Stage two: drop the fraction, add the centre and clamp to 32 bits.
  assign shifted  = s1_sum_r[obce_pkg::SUM_W-1:obce_pkg::TRIG_FRAC];
  assign ctr      = s1_k_r[0] ? cy_r : cx_r;
  assign pos_wide = {shifted[41], shifted} + {{11{ctr[31]}}, ctr};
  assign ovf      = !((&pos_wide[42:31]) || !(|pos_wide[42:31]));
  assign sat_val  = ovf ? (pos_wide[42] ? 32'sh80000000 : 32'sh7fffffff) : pos_wide[31:0];

  // Corner pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= (state_r == obce_pkg::ST_CORN) && (step_r < 4'd8);
      s2_v_r <= s1_v_r;
    end
  end

  // Corner pipeline data and saturation flag.
  always_ff @(posedge clk) begin
    s1_sum_r <= sum_nxt;
    s1_k_r   <= step_r[2:0];
    s2_k_r   <= s1_k_r;
    s2_val_r <= sat_val;
    if (in_accept) begin
      sat_r <= 1'b0;
    end else if (s1_v_r && ovf) begin
      sat_r <= 1'b1;
    end
    if (s1_v_r && !s1_k_r[0]) begin
      x_hold_r <= sat_val;
    end
  end

  // Corner memory write and registered read.
  always_ff @(posedge clk) begin
    if (s1_v_r && s1_k_r[0]) begin
      corner_mem[s1_k_r[2:1]] <= {x_hold_r, sat_val};
    end
    rd_r     <= corner_mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
  end

  // A corner never written reads as zero.
  assign rdata = rd_vld_r ? rd_r : 64'd0;

  // Stage three: running extent over the new corners.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_min_x_r <= '0;
      ext_max_x_r <= '0;
      ext_min_y_r <= '0;
      ext_max_y_r <= '0;
    end else if (s2_v_r) begin
      if (!s2_k_r[0]) begin
        if (s2_k_r[2:1] == 2'd0 || s2_val_r < ext_min_x_r) ext_min_x_r <= s2_val_r;
        if (s2_k_r[2:1] == 2'd0 || s2_val_r > ext_max_x_r) ext_max_x_r <= s2_val_r;
      end else begin
        if (s2_k_r[2:1] == 2'd0 || s2_val_r < ext_min_y_r) ext_min_y_r <= s2_val_r;
        if (s2_k_r[2:1] == 2'd0 || s2_val_r > ext_max_y_r) ext_max_y_r <= s2_val_r;
      end
    end
  end

  // Edge choice: the larger projection wins, ties go to the local Y axis.
  assign ax = px_r[obce_pkg::PROJ_W-1] ? -px_r : px_r;
  assign ay = py_r[obce_pkg::PROJ_W-1] ? -py_r : py_r;

  always_comb begin
    if (ax > ay) begin
      code_nxt = (!px_r[obce_pkg::PROJ_W-1] && (|px_r)) ?
                 obce_pkg::EDGE_RIGHT : obce_pkg::EDGE_LEFT;
    end else begin
      code_nxt = (!py_r[obce_pkg::PROJ_W-1] && (|py_r)) ?
                 obce_pkg::EDGE_BOTTOM : obce_pkg::EDGE_TOP;
    end
  end

  // Query projections, edge code and edge corners.
  always_ff @(posedge clk) begin
    if (state_r == obce_pkg::ST_QRY) begin
      case (step_r)
        4'd1: t_r  <= prod[32:0];
        4'd2: px_r <= {t_r[32], t_r} + {prod[32], prod[32:0]};
        4'd3: t_r  <= prod[32:0];
        4'd4: px_r <= px_r;
        4'd5: code_r  <= code_nxt;
        4'd7: start_r <= rdata;
        4'd8: end_r   <= rdata;
        default: ;
      endcase
      if (step_r == 4'd4) begin
        py_r <= {t_r[32], t_r} - {prod[32], prod[32:0]};
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register word; update results carry no edge.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_min_x_r <= ext_min_x_r;
      out_max_x_r <= ext_max_x_r;
      out_min_y_r <= ext_min_y_r;
      out_max_y_r <= ext_max_y_r;
      out_sat_r   <= cmd_r ? 1'b0 : sat_r;
      out_code_r  <= cmd_r ? code_r : obce_pkg::EDGE_TOP;
      out_sx_r    <= cmd_r ? start_r[63:32] : 32'sd0;
      out_sy_r    <= cmd_r ? start_r[31:0]  : 32'sd0;
      out_ex_r    <= cmd_r ? end_r[63:32]   : 32'sd0;
      out_ey_r    <= cmd_r ? end_r[31:0]    : 32'sd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_extent_min_x = out_min_x_r;
  assign out_extent_max_x = out_max_x_r;
  assign out_extent_min_y = out_min_y_r;
  assign out_extent_max_y = out_max_y_r;
  assign out_edge_code    = out_code_r;
  assign out_edge_start_x = out_sx_r;
  assign out_edge_start_y = out_sy_r;
  assign out_edge_end_x   = out_ex_r;
  assign out_edge_end_y   = out_ey_r;
  assign out_saturated    = out_sat_r;

endmodule

`default_nettype wire

>>> hdl/obce_chk.sv
`default_nettype none

// Port-level checks for the oriented box block.
module obce_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_extent_min_x,
  input logic signed [31:0] out_extent_max_x,
  input logic signed [31:0] out_extent_min_y,
  input logic signed [31:0] out_extent_max_y,
  input logic [1:0]         out_edge_code,
  input logic signed [31:0] out_edge_start_x,
  input logic signed [31:0] out_edge_start_y,
  input logic signed [31:0] out_edge_end_x,
  input logic signed [31:0] out_edge_end_y,
  input logic               out_saturated
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its minimum x and maximum y extent.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_extent_min_x) && $stable(out_extent_max_y))
    else $error("stalled result word changed");

  // The block works on one word at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  // Only updates saturate, so a saturated result carries no edge.
  a_sat_no_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_edge_code == obce_pkg::EDGE_TOP &&
      out_edge_start_x == 32'sd0 && out_edge_start_y == 32'sd0 &&
      out_edge_end_x == 32'sd0 && out_edge_end_y == 32'sd0)
    else $error("saturated result carries an edge");

  // Extent bounds are ordered.
  a_extent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_extent_min_x <= out_extent_max_x &&
      out_extent_min_y <= out_extent_max_y)
    else $error("extent minimum above maximum");

endmodule

bind oriented_box_corners_and_edge_select obce_chk u_obce_chk (.*);

`default_nettype wire

>>> test/tb_oriented_box_corners_and_edge_select.sv
`default_nettype none

module tb_oriented_box_corners_and_edge_select;
  import obce_pkg::*;

  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 40;
  localparam int RUN_LIMIT        = 2_000_000;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } box_cmd_t;

  typedef struct {
    box_cmd_t           command;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic signed [15:0] cos_rot;
    logic signed [15:0] sin_rot;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
  } box_item_t;

  typedef struct {
    logic signed [31:0] min_x;
    logic signed [31:0] max_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_y;
    edge_t              code;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic               sat;
  } box_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [0:0]         cfg_index = '0;
  logic [30:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_command = 1'b0;
  logic signed [31:0] in_center_x = '0;
  logic signed [31:0] in_center_y = '0;
  logic [15:0]        in_scale_x = '0;
  logic [15:0]        in_scale_y = '0;
  logic signed [15:0] in_cos_rot = '0;
  logic signed [15:0] in_sin_rot = '0;
  logic signed [15:0] in_normal_x = '0;
  logic signed [15:0] in_normal_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_extent_min_x;
  logic signed [31:0] out_extent_max_x;
  logic signed [31:0] out_extent_min_y;
  logic signed [31:0] out_extent_max_y;
  logic [1:0]         out_edge_code;
  logic signed [31:0] out_edge_start_x;
  logic signed [31:0] out_edge_start_y;
  logic signed [31:0] out_edge_end_x;
  logic signed [31:0] out_edge_end_y;
  logic               out_saturated;

  // Predicted block state: sizes, stored corners and local axes.
  logic [30:0]        box_width_q = '0;
  logic [30:0]        box_height_q = '0;
  logic signed [31:0] corner_x_q[4] = '{default: '0};
  logic signed [31:0] corner_y_q[4] = '{default: '0};
  logic signed [15:0] axis_cos_q = 16'sd16384;
  logic signed [15:0] axis_sin_q = 16'sd0;

  box_item_t   pending_items[$];
  box_result_t expected_results[$];
  box_item_t   offered;
  logic        tx_busy;
  int          tx_gap_left = 0;
  int          tx_gap_max = 0;
  int          rx_wait_left = 0;
  int          rx_wait_max = 0;
  int          rx_hold_left = 0;
  int          results_seen = 0;
  int          fail_count = 0;
  int          pose_updates = 0;
  int          clamped_updates = 0;
  int          edge_queries = 0;
  int          edge_hits[4] = '{default: 0};

  oriented_box_corners_and_edge_select i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_scale_x       (in_scale_x),
    .in_scale_y       (in_scale_y),
    .in_cos_rot       (in_cos_rot),
    .in_sin_rot       (in_sin_rot),
    .in_normal_x      (in_normal_x),
    .in_normal_y      (in_normal_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_extent_min_x (out_extent_min_x),
    .out_extent_max_x (out_extent_max_x),
    .out_extent_min_y (out_extent_min_y),
    .out_extent_max_y (out_extent_max_y),
    .out_edge_code    (out_edge_code),
    .out_edge_start_x (out_edge_start_x),
    .out_edge_start_y (out_edge_start_y),
    .out_edge_end_x   (out_edge_end_x),
    .out_edge_end_y   (out_edge_end_y),
    .out_saturated    (out_saturated)
  );

  always #2 clk = ~clk;

  // Clamp a Q16.16 coordinate to 32 bits and note any clipping.
  function automatic logic signed [31:0] clamp_q16(input longint v, inout logic clipped);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      clipped = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -longint'(64'sd2147483648)) begin
      clipped = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Work out the result word of one accepted input word and update the box state.
  function automatic void predict_box_result(input box_item_t it);
    box_result_t r;
    longint      half_w, half_h, dx, dy, cx, cy, cs, sn, nx, ny, px, py, ax, ay;
    longint      bias;
    logic [1:0]  first, second;
    logic        sat;
    int          k;
    bias = longint'(1) <<< (TRIG_FRAC - 1);
    sat = 1'b0;
    r.code = EDGE_TOP;
    r.start_x = '0;
    r.start_y = '0;
    r.end_x = '0;
    r.end_y = '0;
    if (it.command == CMD_UPDATE) begin
      cx = longint'(it.center_x);
      cy = longint'(it.center_y);
      cs = longint'(it.cos_rot);
      sn = longint'(it.sin_rot);
      half_w = (longint'(box_width_q) * longint'(it.scale_x)) >>> HALF_SHIFT;
      half_h = (longint'(box_height_q) * longint'(it.scale_y)) >>> HALF_SHIFT;
      // Corners run top-left, top-right, bottom-right, bottom-left.
      for (k = 0; k < 4; k++) begin
        dx = (k == 0 || k == 3) ? -half_w : half_w;
        dy = (k < 2) ? -half_h : half_h;
        corner_x_q[k] = clamp_q16(((dx * cs - dy * sn + bias) >>> TRIG_FRAC) + cx, sat);
        corner_y_q[k] = clamp_q16(((dx * sn + dy * cs + bias) >>> TRIG_FRAC) + cy, sat);
      end
      axis_cos_q = it.cos_rot;
      axis_sin_q = it.sin_rot;
      pose_updates++;
      if (sat) clamped_updates++;
    end else begin
      // Project the normal on both local axes; the Y axis wins a tie.
      nx = longint'(it.normal_x);
      ny = longint'(it.normal_y);
      cs = longint'(axis_cos_q);
      sn = longint'(axis_sin_q);
      px = nx * cs + ny * sn;
      py = ny * cs - nx * sn;
      ax = (px < 0) ? -px : px;
      ay = (py < 0) ? -py : py;
      if (ax > ay) r.code = (px > 0) ? EDGE_RIGHT : EDGE_LEFT;
      else r.code = (py > 0) ? EDGE_BOTTOM : EDGE_TOP;
      case (r.code)
        EDGE_TOP: begin
          first = 2'd0;
          second = 2'd1;
        end
        EDGE_LEFT: begin
          first = 2'd3;
          second = 2'd0;
        end
        EDGE_BOTTOM: begin
          first = 2'd2;
          second = 2'd3;
        end
        default: begin
          first = 2'd1;
          second = 2'd2;
        end
      endcase
      r.start_x = corner_x_q[first];
      r.start_y = corner_y_q[first];
      r.end_x = corner_x_q[second];
      r.end_y = corner_y_q[second];
      edge_queries++;
      edge_hits[r.code]++;
    end
    // The extent always comes from the stored corners.
    r.min_x = corner_x_q[0];
    r.max_x = corner_x_q[0];
    r.min_y = corner_y_q[0];
    r.max_y = corner_y_q[0];
    for (k = 1; k < 4; k++) begin
      if (corner_x_q[k] < r.min_x) r.min_x = corner_x_q[k];
      if (corner_x_q[k] > r.max_x) r.max_x = corner_x_q[k];
      if (corner_y_q[k] < r.min_y) r.min_y = corner_y_q[k];
      if (corner_y_q[k] > r.max_y) r.max_y = corner_y_q[k];
    end
    r.sat = sat;
    expected_results.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  // Mostly unit vectors, some axis-aligned, some anywhere in range, a few raw noise.
  function automatic void draw_direction(output logic signed [15:0] a,
                                         output logic signed [15:0] b);
    real ang;
    int  pick;
    pick = $urandom_range(0, 9);
    ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
    if (pick < 6) begin
      a = 16'($rtoi(16384.0 * $cos(ang)));
      b = 16'($rtoi(16384.0 * $sin(ang)));
    end else if (pick == 6) begin
      a = 16'(($urandom_range(0, 2) - 1) * 16384);
      b = 16'(($urandom_range(0, 2) - 1) * 16384);
    end else if (pick < 9) begin
      a = 16'($urandom_range(0, 32768) - 16384);
      b = 16'($urandom_range(0, 32768) - 16384);
    end else begin
      a = 16'($urandom);
      b = 16'($urandom);
    end
  endfunction

  function automatic box_item_t random_item();
    box_item_t it;
    it.command = ($urandom_range(0, 99) < 40) ? CMD_UPDATE : CMD_QUERY;
    if ($urandom_range(0, 9) == 0) begin
      it.center_x = $urandom;
      it.center_y = $urandom;
    end else begin
      it.center_x = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      it.center_y = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    end
    if ($urandom_range(0, 3) == 0) begin
      it.scale_x = 16'($urandom_range(0, 16'hFFFF));
      it.scale_y = 16'($urandom_range(0, 16'hFFFF));
    end else begin
      it.scale_x = 16'($urandom_range(0, 1024));
      it.scale_y = 16'($urandom_range(0, 1024));
    end
    draw_direction(it.cos_rot, it.sin_rot);
    draw_direction(it.normal_x, it.normal_y);
    return it;
  endfunction

  function automatic box_item_t update_item(input logic signed [31:0] cx,
                                            input logic signed [31:0] cy,
                                            input logic [15:0] sx, input logic [15:0] sy,
                                            input logic signed [15:0] c,
                                            input logic signed [15:0] s);
    box_item_t it;
    it = random_item();
    it.command = CMD_UPDATE;
    it.center_x = cx;
    it.center_y = cy;
    it.scale_x = sx;
    it.scale_y = sy;
    it.cos_rot = c;
    it.sin_rot = s;
    return it;
  endfunction

  function automatic box_item_t query_item(input logic signed [15:0] nx,
                                           input logic signed [15:0] ny);
    box_item_t it;
    it = random_item();
    it.command = CMD_QUERY;
    it.normal_x = nx;
    it.normal_y = ny;
    return it;
  endfunction

  // Sender: offer queued words after a random gap and predict each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap_left = 0;
    end else begin
      tx_busy = in_valid;
      if (in_valid && !in_stall) begin
        predict_box_result(offered);
        tx_busy = 1'b0;
      end
      if (!tx_busy) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          offered = pending_items.pop_front();
          in_command <= offered.command;
          in_center_x <= offered.center_x;
          in_center_y <= offered.center_y;
          in_scale_x <= offered.scale_x;
          in_scale_y <= offered.scale_y;
          in_cos_rot <= offered.cos_rot;
          in_sin_rot <= offered.sin_rot;
          in_normal_x <= offered.normal_x;
          in_normal_y <= offered.normal_y;
          in_valid <= 1'b1;
          tx_gap_left = $urandom_range(0, tx_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted result word, then stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with no prediction pending");
          fail_count++;
        end else begin
          check_field("extent_min_x", expected_results[0].min_x, out_extent_min_x);
          check_field("extent_max_x", expected_results[0].max_x, out_extent_max_x);
          check_field("extent_min_y", expected_results[0].min_y, out_extent_min_y);
          check_field("extent_max_y", expected_results[0].max_y, out_extent_max_y);
          check_field("edge_code", 32'(expected_results[0].code), 32'(out_edge_code));
          check_field("edge_start_x", expected_results[0].start_x, out_edge_start_x);
          check_field("edge_start_y", expected_results[0].start_y, out_edge_start_y);
          check_field("edge_end_x", expected_results[0].end_x, out_edge_end_x);
          check_field("edge_end_y", expected_results[0].end_y, out_edge_end_y);
          check_field("saturated", 32'(expected_results[0].sat), 32'(out_saturated));
          void'(expected_results.pop_front());
        end
        results_seen++;
        // Two long hold-offs let the block back up into its input.
        if (results_seen == 150 || results_seen == 900) rx_hold_left = LONG_HOLD_CYCLES;
        rx_wait_left = $urandom_range(0, rx_wait_max);
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else if (rx_wait_left > 0) begin
        rx_wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [30:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_BOX_WIDTH) box_width_q = value;
    else box_height_q = value;
  endtask

  // Hold the sender until every predicted word has come back, then let the block settle.
  // The queues and the valid are looked at mid-cycle, once the edge has fully settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [30:0] width, input logic [30:0] height,
                           input int count, input int tx_max, input int rx_max);
    int n;
    write_reg(REG_BOX_WIDTH, width);
    write_reg(REG_BOX_HEIGHT, height);
    tx_gap_max = tx_max;
    rx_wait_max = rx_max;
    for (n = 0; n < count / 2; n++) pending_items.push_back(random_item());
    wait_drained();
    for (n = count / 2; n < count; n++) pending_items.push_back(random_item());
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    tx_gap_max = 14;
    rx_wait_max = 14;

    // Queries against the reset box and identity axes.
    pending_items.push_back(query_item(16'sd0, 16'sd0));
    pending_items.push_back(query_item(16'sd16384, 16'sd0));
    wait_drained();

    // Directed poses and normals: axis picks, ties, extremes, clipping.
    write_reg(REG_BOX_WIDTH, 31'h0005_0000);
    write_reg(REG_BOX_HEIGHT, 31'h0003_0000);
    pending_items.push_back(update_item(32'sd0, 32'sd0, 16'd256, 16'd256,
                                        16'sd16384, 16'sd0));
    pending_items.push_back(query_item(16'sd16384, 16'sd0));
    pending_items.push_back(query_item(-16'sd16384, 16'sd0));
    pending_items.push_back(query_item(16'sd0, 16'sd16384));
    pending_items.push_back(query_item(16'sd0, -16'sd16384));
    pending_items.push_back(query_item(16'sd8192, 16'sd8192));
    pending_items.push_back(query_item(16'sd8192, -16'sd8192));
    pending_items.push_back(query_item(16'sd0, 16'sd0));
    pending_items.push_back(query_item(16'sh8000, 16'sh7FFF));
    pending_items.push_back(query_item(16'sh7FFF, 16'sh8000));
    pending_items.push_back(update_item(32'sh0010_0000, -32'sh0020_0000, 16'd256, 16'd512,
                                        16'sd0, 16'sd16384));
    pending_items.push_back(query_item(16'sd16384, 16'sd0));
    pending_items.push_back(update_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF,
                                        16'sd16384, 16'sd0));
    pending_items.push_back(query_item(-16'sd16384, -16'sd16384));
    pending_items.push_back(update_item(32'sh8000_0000, 32'sh8000_0000, 16'hFFFF, 16'hFFFF,
                                        16'sd16384, 16'sd0));
    pending_items.push_back(update_item(32'sd0, 32'sd0, 16'hFFFF, 16'hFFFF,
                                        16'sh8000, 16'sh7FFF));
    pending_items.push_back(query_item(16'sh7FFF, 16'sh7FFF));
    pending_items.push_back(update_item(32'sd12345, -32'sd54321, 16'd0, 16'd0,
                                        16'sd11585, 16'sd11585));
    pending_items.push_back(update_item(32'sh0001_0000, 32'sh0001_0000, 16'd256, 16'd256,
                                        16'sd0, 16'sd0));
    pending_items.push_back(update_item(32'sh8000_0000, 32'sh7FFF_FFFF, 16'd128, 16'd384,
                                        -16'sd16384, -16'sd16384));
    pending_items.push_back(query_item(16'sh8000, 16'sh8000));
    wait_drained();

    // Random phases over several size settings, including both extremes.
    run_phase(31'($urandom_range(0, 32'h00FF_FFFF)), 31'($urandom_range(0, 32'h00FF_FFFF)),
              350, 14, 14);
    run_phase(31'h0000_0000, 31'h0000_0000, 150, 0, 0);
    run_phase(31'h7FFF_FFFF, 31'h7FFF_FFFF, 200, 14, 14);
    run_phase(31'($urandom), 31'($urandom_range(0, 32'h000F_FFFF)), 300, 3, 14);
    run_phase(31'($urandom_range(0, 32'h00FF_FFFF)), 31'($urandom_range(0, 32'h00FF_FFFF)),
              300, 14, 0);
    run_phase(31'($urandom_range(0, 32'h0FFF_FFFF)), 31'h7FFF_FFFF, 400, 14, 14);

    $display("Covered %0d pose updates (%0d with clipped corners) and %0d edge queries.",
             pose_updates, clamped_updates, edge_queries);
    $display("Edges picked: top %0d, left %0d, bottom %0d, right %0d.",
             edge_hits[0], edge_hits[1], edge_hits[2], edge_hits[3]);
    if (fail_count == 0) begin
      $display("tb_oriented_box_corners_and_edge_select OK");
    end else begin
      $display("tb_oriented_box_corners_and_edge_select NOT OK");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(RUN_LIMIT);
    $display("tb_oriented_box_corners_and_edge_select NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

>>> oriented_box_corners_and_edge_select.f
hdl/obce_pkg.sv
hdl/obce_mul.sv
hdl/oriented_box_corners_and_edge_select.sv
hdl/obce_chk.sv
test/tb_oriented_box_corners_and_edge_select.sv
